### rtl/xxt_pkg.sv
// Shared constants and helpers for the XXTEA block cipher.
`default_nettype none
package xxt_pkg;

    localparam int unsigned XXT_MAX_WORDS = 16;
    localparam int unsigned WORD_W        = 32;
    localparam int unsigned LEN_REG_W     = 5;
    localparam int unsigned ROUND_W       = 6;
    localparam int unsigned CFG_IDX_W     = 3;

    localparam logic [WORD_W-1:0] XXT_DELTA = 32'h9e37_79b9;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CIPHER_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_WORDS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3  = 3'd5;

    localparam logic CIPHER_ENCRYPT = 1'b0;
    localparam logic CIPHER_DECRYPT = 1'b1;

    // 6 + 52/len for the lengths a 5-bit register can hold
    function automatic logic [ROUND_W-1:0] rounds_for(input logic [LEN_REG_W-1:0] len);
        logic [ROUND_W-1:0] r;
        priority if (len <= 5'd1)  r = 6'd58;
        else if (len == 5'd2)      r = 6'd32;
        else if (len == 5'd3)      r = 6'd23;
        else if (len == 5'd4)      r = 6'd19;
        else if (len == 5'd5)      r = 6'd16;
        else if (len == 5'd6)      r = 6'd14;
        else if (len == 5'd7)      r = 6'd13;
        else if (len == 5'd8)      r = 6'd12;
        else if (len <= 5'd10)     r = 6'd11;
        else if (len <= 5'd13)     r = 6'd10;
        else if (len <= 5'd17)     r = 6'd9;
        else if (len <= 5'd26)     r = 6'd8;
        else                       r = 6'd7;
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/xxt_word_buffer.sv
// Block word store: one write port, two registered read ports.
`default_nettype none
module xxt_word_buffer
    import xxt_pkg::*;
#(
    parameter int unsigned DEPTH = XXT_MAX_WORDS
)
(
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WORD_W-1:0]        wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic      [WORD_W-1:0]        rd_data_a,
    output logic      [WORD_W-1:0]        rd_data_b
);

    logic [WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule
`default_nettype wire

### rtl/xxt_mix_unit.sv
// XXTEA MX mix function, shared by every word update.
`default_nettype none
module xxt_mix_unit
    import xxt_pkg::*;
(
    input  wire logic [WORD_W-1:0] z,
    input  wire logic [WORD_W-1:0] y,
    input  wire logic [WORD_W-1:0] sum,
    input  wire logic [WORD_W-1:0] key,
    output logic      [WORD_W-1:0] mix
);

    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    logic [WORD_W-1:0] d;

    always_comb
    begin
        a   = (z >> 5) ^ (y << 2);
        b   = (y >> 3) ^ (z << 4);
        c   = sum ^ y;
        d   = key ^ z;
        mix = (a + b) ^ (c + d);
    end

endmodule
`default_nettype wire

### rtl/xxtea_block_cipher_top.sv
// XXTEA block cipher top level: config registers, sequencer, buffer and mix unit.
//
//  channel   signals                              direction
//  in        in_valid / in_ready, data_word        words of a block, index order
//  out       out_valid / out_ready, result_word,   transformed words, index order
//            final_word
//  cfg       cfg_wr_en, cfg_index, cfg_data        register writes, no handshake
//
// Loading accepts one word per cycle while in_valid is high. A block of n>1 words
// then goes through the sequencer's init and start states and 6 + 52/n rounds of n
// word updates: each word update uses the one mix unit over read, mix and write
// states against the two-read-port buffer. Output reads each word, then holds it
// while out_ready is low; in_ready is low from block completion until the final word is transferred.
// Reset sets the config registers to defaults and clears the sequencer but mix_reg; the buffer is not cleared.
`default_nettype none
module xxtea_block_cipher_top
    import xxt_pkg::*;
#(
    parameter int unsigned MAX_WORDS = XXT_MAX_WORDS
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [WORD_W-1:0]    data_word,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic      [WORD_W-1:0]    result_word,
    output logic                      final_word,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [WORD_W-1:0]    cfg_data
);

    localparam int unsigned ADDR_W = $clog2(MAX_WORDS);
    localparam int unsigned CNT_W  = $clog2(MAX_WORDS + 1);

    localparam logic [2:0] S_LOAD   = 3'd0;
    localparam logic [2:0] S_INIT   = 3'd1;
    localparam logic [2:0] S_START  = 3'd2;
    localparam logic [2:0] S_READ   = 3'd3;
    localparam logic [2:0] S_MIX    = 3'd4;
    localparam logic [2:0] S_WRITE  = 3'd5;
    localparam logic [2:0] S_OUT_RD = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    // configuration
    logic                 mode_reg;
    logic [LEN_REG_W-1:0] block_words_reg;
    logic [WORD_W-1:0]    key_reg [4];

    // sequencer
    logic [2:0]         state_reg, state_next;
    logic [CNT_W-1:0]   load_count_reg, load_count_next;
    logic [ROUND_W-1:0] rounds_reg, rounds_next;
    logic [WORD_W-1:0]  sum_reg, sum_next;
    logic [WORD_W-1:0]  carry_reg, carry_next;
    logic [WORD_W-1:0]  mix_reg, mix_next;
    logic [ADDR_W-1:0]  p_reg, p_next;

    logic [CNT_W-1:0]         eff_len;
    logic [ADDR_W-1:0]        last_idx;
    logic [CNT_W-1:0]         load_idx;
    logic [CNT_W-1:0]         load_after;
    logic [ROUND_W-1:0]       start_rounds;
    logic [WORD_W-1:0]        start_sum_prod;
    logic [1:0]               p_lo;
    logic [WORD_W-1:0]        key_sel;
    logic [WORD_W-1:0]        mix_z;
    logic [WORD_W-1:0]        mix_y;
    logic [WORD_W-1:0]        mix_val;
    logic [WORD_W-1:0]        updated_word;

    logic                 buf_wr_en;
    logic [ADDR_W-1:0]    buf_wr_addr;
    logic [WORD_W-1:0]    buf_wr_data;
    logic [ADDR_W-1:0]    buf_rd_addr_a;
    logic [ADDR_W-1:0]    buf_rd_addr_b;
    logic [WORD_W-1:0]    buf_rd_data_a;
    logic [WORD_W-1:0]    buf_rd_data_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= CIPHER_ENCRYPT;
            block_words_reg <= 5'd2;
            key_reg[0]      <= '0;
            key_reg[1]      <= '0;
            key_reg[2]      <= '0;
            key_reg[3]      <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_CIPHER_MODE: mode_reg        <= cfg_data[0];
                REG_BLOCK_WORDS: block_words_reg <= cfg_data[LEN_REG_W-1:0];
                REG_KEY_WORD_0:  key_reg[0]      <= cfg_data;
                REG_KEY_WORD_1:  key_reg[1]      <= cfg_data;
                REG_KEY_WORD_2:  key_reg[2]      <= cfg_data;
                REG_KEY_WORD_3:  key_reg[3]      <= cfg_data;
                default: ;
            endcase
        end
    end

    // zero counts as one, anything above the buffer depth saturates
    always_comb
    begin
        if (block_words_reg == '0)
            eff_len = CNT_W'(1);
        else if (32'(block_words_reg) > MAX_WORDS)
            eff_len = CNT_W'(MAX_WORDS);
        else
            eff_len = CNT_W'(block_words_reg);
    end

    assign last_idx       = ADDR_W'(eff_len - CNT_W'(1));
    assign load_idx       = (load_count_reg >= eff_len) ? '0 : load_count_reg;
    assign load_after     = load_idx + CNT_W'(1);
    assign start_rounds   = rounds_for(LEN_REG_W'(eff_len));
    assign start_sum_prod = WORD_W'(start_rounds) * XXT_DELTA;

    assign p_lo    = 2'(p_reg);
    assign key_sel = key_reg[p_lo ^ sum_reg[3:2]];

    // neighbour addresses wrap round the block
    always_comb
    begin
        if (state_reg == S_INIT)
            buf_rd_addr_a = (mode_reg == CIPHER_DECRYPT) ? '0 : last_idx;
        else
            buf_rd_addr_a = p_reg;

        if (mode_reg == CIPHER_DECRYPT)
            buf_rd_addr_b = (p_reg == '0) ? last_idx : p_reg - ADDR_W'(1);
        else
            buf_rd_addr_b = (p_reg == last_idx) ? '0 : p_reg + ADDR_W'(1);
    end

    assign mix_z = (mode_reg == CIPHER_DECRYPT) ? buf_rd_data_b : carry_reg;
    assign mix_y = (mode_reg == CIPHER_DECRYPT) ? carry_reg : buf_rd_data_b;

    xxt_mix_unit u_mix (
        .z   (mix_z),
        .y   (mix_y),
        .sum (sum_reg),
        .key (key_sel),
        .mix (mix_val)
    );

    assign updated_word = (mode_reg == CIPHER_DECRYPT) ? buf_rd_data_a - mix_reg
                                                       : buf_rd_data_a + mix_reg;

    always_comb
    begin
        buf_wr_en   = 1'b0;
        buf_wr_addr = p_reg;
        buf_wr_data = updated_word;
        if (state_reg == S_LOAD)
        begin
            buf_wr_en   = in_valid;
            buf_wr_addr = ADDR_W'(load_idx);
            buf_wr_data = data_word;
        end
        else if (state_reg == S_WRITE)
        begin
            buf_wr_en = 1'b1;
        end
    end

    xxt_word_buffer #(
        .DEPTH (MAX_WORDS)
    ) u_buffer (
        .clk       (clk),
        .wr_en     (buf_wr_en),
        .wr_addr   (buf_wr_addr),
        .wr_data   (buf_wr_data),
        .rd_addr_a (buf_rd_addr_a),
        .rd_addr_b (buf_rd_addr_b),
        .rd_data_a (buf_rd_data_a),
        .rd_data_b (buf_rd_data_b)
    );

    always_comb
    begin
        state_next      = state_reg;
        load_count_next = load_count_reg;
        rounds_next     = rounds_reg;
        sum_next        = sum_reg;
        carry_next      = carry_reg;
        mix_next        = mix_reg;
        p_next          = p_reg;

        unique case (state_reg)
            S_LOAD:
            begin
                if (in_valid)
                begin
                    if (load_after == eff_len)
                    begin
                        load_count_next = '0;
                        p_next          = '0;
                        state_next      = (eff_len == CNT_W'(1)) ? S_OUT_RD : S_INIT;
                    end
                    else
                    begin
                        load_count_next = load_after;
                    end
                end
            end
            S_INIT:
            begin
                state_next = S_START;
            end
            S_START:
            begin
                carry_next = buf_rd_data_a;
                if (mode_reg == CIPHER_DECRYPT)
                begin
                    rounds_next = start_rounds;
                    sum_next    = start_sum_prod;
                    p_next      = last_idx;
                end
                else
                begin
                    // first round begins here
                    rounds_next = start_rounds - ROUND_W'(1);
                    sum_next    = XXT_DELTA;
                    p_next      = '0;
                end
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_MIX;
            end
            S_MIX:
            begin
                mix_next   = mix_val;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                carry_next = updated_word;
                state_next = S_READ;
                if (mode_reg == CIPHER_DECRYPT)
                begin
                    if (p_reg == '0)
                    begin
                        sum_next    = sum_reg - XXT_DELTA;
                        rounds_next = rounds_reg - ROUND_W'(1);
                        if (rounds_reg == ROUND_W'(1))
                        begin
                            p_next     = '0;
                            state_next = S_OUT_RD;
                        end
                        else
                        begin
                            p_next = last_idx;
                        end
                    end
                    else
                    begin
                        p_next = p_reg - ADDR_W'(1);
                    end
                end
                else
                begin
                    if (p_reg == last_idx)
                    begin
                        p_next = '0;
                        if (rounds_reg == '0)
                        begin
                            state_next = S_OUT_RD;
                        end
                        else
                        begin
                            rounds_next = rounds_reg - ROUND_W'(1);
                            sum_next    = sum_reg + XXT_DELTA;
                        end
                    end
                    else
                    begin
                        p_next = p_reg + ADDR_W'(1);
                    end
                end
            end
            S_OUT_RD:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    if (p_reg == last_idx)
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        p_next     = p_reg + ADDR_W'(1);
                        state_next = S_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            load_count_reg <= '0;
            rounds_reg     <= '0;
            sum_reg        <= '0;
            carry_reg      <= '0;
            p_reg          <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            rounds_reg     <= rounds_next;
            sum_reg        <= sum_next;
            carry_reg      <= carry_next;
            p_reg          <= p_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mix_reg <= mix_next;
    end

    // buffer keeps rereading the same word while the transfer stalls
    assign in_ready    = (state_reg == S_LOAD);
    assign out_valid   = (state_reg == S_OUT);
    assign result_word = buf_rd_data_a;
    assign final_word  = (p_reg == last_idx);

endmodule
`default_nettype wire
